// File: sv/spq_pkg.sv
// spq_pkg: shared constants, types and codes for the sorted priority queue
// no dependencies; imported by every module of the queue
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int TAG_BITS  = 32;
    localparam int PRIO_BITS = 16;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CHANGE  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NOT_LOWER = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_CLEAR
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REMOVE,
        S_INSERT,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic [TAG_BITS-1:0]  tag;
        logic [PRIO_BITS-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [TAG_BITS-1:0]  removed_tag;
        logic [PRIO_BITS-1:0] removed_priority;
        logic [TAG_BITS-1:0]  head_tag;
        logic [PRIO_BITS-1:0] head_priority;
        logic [CNT_BITS-1:0]  entry_count;
        logic                 is_empty;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [TAG_BITS-1:0]  tag;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cell_cmd            cmd;
        logic                 chain_in;
        logic [TAG_BITS-1:0]  tag;
        logic [PRIO_BITS-1:0] prio;
    } t_chain_cmd;

    typedef struct packed {
        logic   found;
        logic   bad;
        t_entry head;
    } t_chain_stat;

endpackage

// File: sv/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_cmd            i_cmd,
    input  logic [TAG_BITS-1:0]  i_req_tag,
    input  logic [PRIO_BITS-1:0] i_req_prio,
    input  t_entry               i_left,
    input  logic                 i_left_le,
    input  t_entry               i_right,
    input  logic                 i_found_in,
    output t_entry               o_entry,
    output logic                 o_le,
    output logic                 o_found_out,
    output logic                 o_bad
);

    logic                 r_valid;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] r_prio;
    t_entry               n_entry;
    logic                 w_match;
    logic                 w_first;

    assign o_entry     = '{valid: r_valid, tag: r_tag, prio: r_prio};
    assign o_le        = r_valid && (r_prio <= i_req_prio);
    assign w_match     = r_valid && (r_tag == i_req_tag);
    assign w_first     = w_match && !i_found_in;
    assign o_found_out = i_found_in || w_match;
    assign o_bad       = w_first && (r_prio <= i_req_prio);

    always_comb begin
        n_entry = o_entry;
        case (i_cmd)
            CELL_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_entry = '{valid: 1'b1, tag: i_req_tag, prio: i_req_prio};
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            CELL_REMOVE: begin
                if (o_found_out) begin
                    n_entry = i_right;
                end
            end
            CELL_CLEAR: begin
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_entry.tag;
        r_prio <= n_entry.prio;
    end

endmodule

// File: sv/spq_chain.sv
// spq_chain: row of slots kept in priority order, head at slot zero
// depends on spq_pkg and spq_cell
module spq_chain import spq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_cmd  i_cmd,
    output t_chain_stat o_stat
);

    t_entry               w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_le;
    logic [CAPACITY-1:0]  w_found;
    logic [CAPACITY-1:0]  w_bad;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_le;
        logic   w_found_in;

        if (k == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_le  = 1'b1;
            assign w_found_in = i_cmd.chain_in;
        end else begin : g_mid
            assign w_left     = w_entry[k-1];
            assign w_left_le  = w_le[k-1];
            assign w_found_in = w_found[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[k+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd.cmd),
            .i_req_tag   (i_cmd.tag),
            .i_req_prio  (i_cmd.prio),
            .i_left      (w_left),
            .i_left_le   (w_left_le),
            .i_right     (w_right),
            .i_found_in  (w_found_in),
            .o_entry     (w_entry[k]),
            .o_le        (w_le[k]),
            .o_found_out (w_found[k]),
            .o_bad       (w_bad[k])
        );
    end

    assign o_stat.found = w_found[CAPACITY-1];
    assign o_stat.bad   = |w_bad;
    assign o_stat.head  = w_entry[0];

endmodule

// File: sv/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue on a chain of sorted slots
// sequence: idle transfer, then exec and report states; the result is registered from report
// handshake: one request at a time; input stalls until idle and the last result is taken
// a change searches the chain, then if found and lower does a remove and an insert step
// reset: synchronous active low, empties the queue and drops any pending result
// depends on spq_pkg and spq_chain
module sorted_priority_queue import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state               r_state;
    t_state               n_state;
    t_in_item             r_req;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    t_status              r_status;
    t_status              n_status;
    logic [TAG_BITS-1:0]  r_rem_tag;
    logic [PRIO_BITS-1:0] r_rem_prio;
    logic                 n_rem;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_chain_cmd           w_cmd;
    t_chain_stat          w_stat;
    logic                 w_in_xfer;
    logic                 w_full;
    logic                 w_empty;

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    spq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_req.op == OP_CHANGE && w_stat.found && !w_stat.bad) begin
                    n_state = S_REMOVE;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_REMOVE: n_state = S_INSERT;
            S_INSERT: n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // chain command, status and count
    always_comb begin
        w_cmd.cmd      = CELL_HOLD;
        w_cmd.chain_in = 1'b0;
        w_cmd.tag      = r_req.tag;
        w_cmd.prio     = r_req.priority_req;
        n_count        = r_count;
        n_status       = r_status;
        n_rem          = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                n_status = ST_OK;
                unique case (r_req.op)
                    OP_ENQUEUE: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd.cmd = CELL_INSERT;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_DEQUEUE: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_cmd.cmd      = CELL_REMOVE;
                            w_cmd.chain_in = 1'b1;
                            n_count        = r_count - 1'b1;
                            n_rem          = 1'b1;
                        end
                    end
                    OP_CHANGE: begin
                        if (!w_stat.found) begin
                            n_status = ST_NOT_FOUND;
                        end else if (w_stat.bad) begin
                            n_status = ST_NOT_LOWER;
                        end
                    end
                    OP_CLEAR: begin
                        w_cmd.cmd = CELL_CLEAR;
                        n_count   = '0;
                    end
                    default: begin
                        w_cmd.cmd = CELL_HOLD;
                    end
                endcase
            end
            S_REMOVE: begin
                w_cmd.cmd = CELL_REMOVE;
                n_count   = r_count - 1'b1;
            end
            S_INSERT: begin
                w_cmd.cmd = CELL_INSERT;
                n_count   = r_count + 1'b1;
            end
            default: begin
                w_cmd.cmd = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_REPORT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req <= i_in_item;
        end
        r_status <= n_status;
        if (r_state == S_EXEC) begin
            r_rem_tag  <= n_rem ? w_stat.head.tag  : '0;
            r_rem_prio <= n_rem ? w_stat.head.prio : '0;
        end
        if (r_state == S_REPORT) begin
            r_out.status           <= r_status;
            r_out.removed_tag      <= r_rem_tag;
            r_out.removed_priority <= r_rem_prio;
            r_out.head_tag         <= w_stat.head.valid ? w_stat.head.tag  : '0;
            r_out.head_priority    <= w_stat.head.valid ? w_stat.head.prio : '0;
            r_out.entry_count      <= r_count;
            r_out.is_empty         <= w_empty;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_empty == !w_stat.head.valid))
        else $error("head slot validity disagrees with count");

    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input transfer possible while a result is pending");

    a_report_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) |=> o_out_valid)
        else $error("result not presented after report step");
`endif

endmodule
